/* hw/rtl/nvqp_pkg.sv */
// ============================================================================
// nvqp_pkg: shared types and constants for the NVMe I/O queue pair host
// Result and item records, register indexes, opcodes and doorbell constants.
// ============================================================================
package nvqp_pkg;

    // Ring limits: effective depth is clamped to [2, DEPTH_CAP]
    localparam int RING_ENTRIES = 32;
    localparam int DEPTH_CAP    = (RING_ENTRIES < 32) ? RING_ENTRIES : 32;

    localparam int PTR_W        = 5;
    localparam int DEPTH_W      = 6;
    localparam int ID_W         = 16;
    localparam int BELL_W       = 23;
    localparam int ERR_W        = 15;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int S_TDATA_W    = 184;
    localparam int M_TDATA_W    = 248;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_QUEUE_DEPTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_LOG    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NAMESPACE_ID  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [DEPTH_W-1:0] QUEUE_DEPTH_RST = 6'd32;
    localparam logic [3:0]         STRIDE_LOG_RST  = 4'd0;
    localparam logic [31:0]        NAMESPACE_RST   = 32'd1;

    // Command encoding
    localparam logic       FUNC_SUBMIT = 1'b0;
    localparam logic [7:0] OP_READ     = 8'h02;
    localparam logic [7:0] OP_WRITE    = 8'h01;

    // Doorbell block starts at 0x1000 from the register base
    localparam logic [BELL_W-1:0] BELL_BASE = 23'h001000;

    localparam logic [ERR_W-1:0] STATUS_MASK = 15'h7FFF;

    typedef enum logic [1:0] {
        KIND_SQE  = 2'd0,
        KIND_BELL = 2'd1,
        KIND_OK   = 2'd2,
        KIND_FAIL = 2'd3
    } kind_t;

    typedef struct packed {
        logic              func;
        logic              is_write;
        logic [63:0]       start_block;
        logic [15:0]       block_count;
        logic [63:0]       data_addr;
        logic [ID_W-1:0]   cqe_id;
        logic [15:0]       cqe_status;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [PTR_W-1:0]   slot;
        logic [7:0]         opcode;
        logic [ID_W-1:0]    cmd_id;
        logic [31:0]        ns_out;
        logic [63:0]        prp_addr;
        logic [63:0]        lba_out;
        logic [15:0]        count_out;
        logic [BELL_W-1:0]  bell_offset;
        logic [PTR_W-1:0]   bell_value;
        logic [ERR_W-1:0]   error_code;
        logic               last;
    } result_t;

    // Up to two results produced by one item
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } pair_t;

    // Settings derived from the configuration registers
    typedef struct packed {
        logic [DEPTH_W-1:0] eff_depth;
        logic [BELL_W-1:0]  sq_bell;
        logic [BELL_W-1:0]  cq_bell;
        logic [31:0]        namespace_id;
    } cfg_t;

endpackage

/* hw/rtl/nvme_io_queue_pair_host.sv */
// ============================================================================
// nvme_io_queue_pair_host: host side of one NVMe I/O queue pair
// Builds submission entries and doorbell writes, checks completion entries.
// ============================================================================
// Usage:
//   Slave channel (s_*): one transfer per command (s_tuser = 0) or per
//   completion entry seen at the CQ head (s_tuser = 1).
//   Master channel (m_*): results; m_tuser gives the kind (entry, doorbell,
//   success, failure) and m_tlast marks the final result of an input.
//   A submit gives two results (SQ entry, SQ doorbell). A good completion
//   gives two (CQ doorbell, success), a bad status one (failure), and a
//   phase or id mismatch none.
//   Path: an item passes the input register, then the result register pair;
//   it waits in the input register until the pair can take it.
//   Throughput: the result register pair drains one transfer per cycle while
//   m_tready is high; a new item's results load as the last result of the
//   previous item leaves, and an ignored completion loads no results.
//   When m_tready is low the result pair holds, then the input register
//   fills and s_tready drops; nothing is lost.
//   Reset (aresetn low, synchronous) empties both registers and sets
//   tail/head 0, phase 1, next id 1, no command outstanding; config
//   registers return to depth 32, stride log 0, namespace 1.
//   Config writes must go in while the block is idle; the block does not enforce it.
// ============================================================================
module nvme_io_queue_pair_host (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [nvqp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nvqp_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata, low to high: is_write, start_block, block_count, data_addr,
    //   cqe_id, cqe_status, 7 zero pad bits
    input  logic [nvqp_pkg::S_TDATA_W-1:0]      s_tdata,
    // tuser: func
    input  logic                                s_tuser,

    // Results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata, low to high: slot, opcode, cmd_id, ns_out, prp_addr, lba_out,
    //   count_out, bell_offset, bell_value, error_code
    output logic [nvqp_pkg::M_TDATA_W-1:0]      m_tdata,
    // tuser: kind
    output logic [1:0]                          m_tuser,
    output logic                                m_tlast
);

    nvqp_pkg::cfg_t      cfg;
    nvqp_pkg::in_item_t  s_item;
    nvqp_pkg::pair_t     pair;
    nvqp_pkg::result_t   m_res;
    logic                load;
    logic                load_ok;

    // Unpack the input transfer
    assign s_item.func        = s_tuser;
    assign s_item.is_write    = s_tdata[0];
    assign s_item.start_block = s_tdata[64:1];
    assign s_item.block_count = s_tdata[80:65];
    assign s_item.data_addr   = s_tdata[144:81];
    assign s_item.cqe_id      = s_tdata[160:145];
    assign s_item.cqe_status  = s_tdata[176:161];

    nvqp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    nvqp_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_item   (s_item),
        .cfg      (cfg),
        .load_ok  (load_ok),
        .load     (load),
        .pair     (pair)
    );

    nvqp_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .pair     (pair),
        .load_ok  (load_ok),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    // Pack the result transfer
    assign m_tdata = {m_res.error_code, m_res.bell_value, m_res.bell_offset,
                      m_res.count_out, m_res.lba_out, m_res.prp_addr,
                      m_res.ns_out, m_res.cmd_id, m_res.opcode, m_res.slot};
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.last;

endmodule

/* hw/rtl/nvqp_cfg.sv */
// ============================================================================
// nvqp_cfg: configuration registers
// Holds depth, doorbell stride and namespace; derives the clamped depth and
// the two doorbell byte offsets.
// ============================================================================
module nvqp_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [nvqp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [nvqp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output nvqp_pkg::cfg_t                     cfg
);

    logic [nvqp_pkg::DEPTH_W-1:0] depth_reg;
    logic [3:0]                   stride_log_reg;
    logic [31:0]                  ns_reg;

    logic [nvqp_pkg::DEPTH_W-1:0] eff_depth;
    logic [nvqp_pkg::BELL_W-1:0]  stride;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg      <= nvqp_pkg::QUEUE_DEPTH_RST;
            stride_log_reg <= nvqp_pkg::STRIDE_LOG_RST;
            ns_reg         <= nvqp_pkg::NAMESPACE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                nvqp_pkg::REG_QUEUE_DEPTH:  depth_reg      <= cfg_wdata[nvqp_pkg::DEPTH_W-1:0];
                nvqp_pkg::REG_STRIDE_LOG:   stride_log_reg <= cfg_wdata[3:0];
                nvqp_pkg::REG_NAMESPACE_ID: ns_reg         <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_depth = depth_reg;
        if (eff_depth > nvqp_pkg::DEPTH_W'(nvqp_pkg::DEPTH_CAP)) begin
            eff_depth = nvqp_pkg::DEPTH_W'(nvqp_pkg::DEPTH_CAP);
        end
        if (eff_depth < 6'd2) begin
            eff_depth = 6'd2;
        end
    end

    // stride = 4 << log, at most 2^17; SQ doorbell index 2, CQ index 3
    assign stride = nvqp_pkg::BELL_W'(4) << stride_log_reg;

    assign cfg.eff_depth    = eff_depth;
    assign cfg.sq_bell      = nvqp_pkg::BELL_BASE + (stride << 1);
    assign cfg.cq_bell      = nvqp_pkg::BELL_BASE + (stride << 1) + stride;
    assign cfg.namespace_id = ns_reg;

endmodule

/* hw/rtl/nvqp_core.sv */
// ============================================================================
// nvqp_core: input register and queue state
// Registers one item, then builds its results against tail, head, phase and
// the outstanding command in a single pass.
// ============================================================================
module nvqp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  nvqp_pkg::in_item_t  s_item,
    input  nvqp_pkg::cfg_t      cfg,
    input  logic                load_ok,
    output logic                load,
    output nvqp_pkg::pair_t     pair
);

    logic                          in_valid_reg, in_valid_next;
    nvqp_pkg::in_item_t            in_reg;

    logic [nvqp_pkg::PTR_W-1:0]    sub_tail_reg, sub_tail_next;
    logic [nvqp_pkg::PTR_W-1:0]    comp_head_reg, comp_head_next;
    logic                          comp_phase_reg, comp_phase_next;
    logic [nvqp_pkg::ID_W-1:0]     next_id_reg, next_id_next;
    logic [nvqp_pkg::ID_W-1:0]     waiting_id_reg, waiting_id_next;
    logic                          waiting_valid_reg, waiting_valid_next;

    logic [nvqp_pkg::ERR_W-1:0]    code;
    logic                          match;

    function automatic logic [nvqp_pkg::PTR_W-1:0] ptr_advance(
        input logic [nvqp_pkg::PTR_W-1:0]   p,
        input logic [nvqp_pkg::DEPTH_W-1:0] depth
    );
        logic [nvqp_pkg::DEPTH_W-1:0] n;
        n = {1'b0, p} + 6'd1;
        return (n >= depth) ? '0 : n[nvqp_pkg::PTR_W-1:0];
    endfunction

    assign load    = in_valid_reg && load_ok;
    assign s_ready = !in_valid_reg || load_ok;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    assign code  = in_reg.cqe_status[15:1] & nvqp_pkg::STATUS_MASK;
    assign match = waiting_valid_reg && (in_reg.cqe_status[0] == comp_phase_reg)
                   && (in_reg.cqe_id == waiting_id_reg);

    always_comb begin
        pair               = '0;
        sub_tail_next      = sub_tail_reg;
        comp_head_next     = comp_head_reg;
        comp_phase_next    = comp_phase_reg;
        next_id_next       = next_id_reg;
        waiting_id_next    = waiting_id_reg;
        waiting_valid_next = waiting_valid_reg;

        if (in_reg.func == nvqp_pkg::FUNC_SUBMIT) begin
            sub_tail_next      = ptr_advance(sub_tail_reg, cfg.eff_depth);
            next_id_next       = next_id_reg + 16'd1;
            waiting_id_next    = next_id_reg;
            waiting_valid_next = 1'b1;

            pair.n            = 2'd2;
            pair.r0.kind      = nvqp_pkg::KIND_SQE;
            pair.r0.slot      = sub_tail_reg;
            pair.r0.opcode    = in_reg.is_write ? nvqp_pkg::OP_WRITE : nvqp_pkg::OP_READ;
            pair.r0.cmd_id    = next_id_reg;
            pair.r0.ns_out    = cfg.namespace_id;
            pair.r0.prp_addr  = in_reg.data_addr;
            pair.r0.lba_out   = in_reg.start_block;
            pair.r0.count_out = in_reg.block_count;

            pair.r1.kind        = nvqp_pkg::KIND_BELL;
            pair.r1.bell_offset = cfg.sq_bell;
            pair.r1.bell_value  = sub_tail_next;
            pair.r1.last        = 1'b1;
        end else if (match) begin
            waiting_valid_next = 1'b0;
            if (code != '0) begin
                pair.n             = 2'd1;
                pair.r0.kind       = nvqp_pkg::KIND_FAIL;
                pair.r0.cmd_id     = in_reg.cqe_id;
                pair.r0.error_code = code;
                pair.r0.last       = 1'b1;
            end else begin
                comp_head_next = ptr_advance(comp_head_reg, cfg.eff_depth);
                if (comp_head_next == '0) begin
                    comp_phase_next = !comp_phase_reg;
                end
                pair.n              = 2'd2;
                pair.r0.kind        = nvqp_pkg::KIND_BELL;
                pair.r0.bell_offset = cfg.cq_bell;
                pair.r0.bell_value  = comp_head_next;
                pair.r1.kind        = nvqp_pkg::KIND_OK;
                pair.r1.cmd_id      = in_reg.cqe_id;
                pair.r1.last        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            sub_tail_reg      <= '0;
            comp_head_reg     <= '0;
            comp_phase_reg    <= 1'b1;
            next_id_reg       <= 16'd1;
            waiting_id_reg    <= '0;
            waiting_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (load) begin
                sub_tail_reg      <= sub_tail_next;
                comp_head_reg     <= comp_head_next;
                comp_phase_reg    <= comp_phase_next;
                next_id_reg       <= next_id_next;
                waiting_id_reg    <= waiting_id_next;
                waiting_valid_reg <= waiting_valid_next;
            end
        end
    end

    // A submit leaves its id outstanding and bumps the id counter
    a_submit_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && in_reg.func == nvqp_pkg::FUNC_SUBMIT) |=>
            (waiting_valid_reg && waiting_id_reg == $past(next_id_reg)
             && next_id_reg == 16'($past(next_id_reg) + 16'd1)))
        else $error("submit did not arm the outstanding command");

    // Any reported completion retires the outstanding command
    a_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && in_reg.func != nvqp_pkg::FUNC_SUBMIT && pair.n != 2'd0) |=>
            !waiting_valid_reg)
        else $error("completion left command outstanding");

endmodule

/* hw/rtl/nvqp_emit.sv */
// ============================================================================
// nvqp_emit: result register pair
// Holds the one or two results of an item and sends them one per cycle while m_ready is high.
// ============================================================================
module nvqp_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  nvqp_pkg::pair_t     pair,
    output logic                load_ok,
    output logic                m_valid,
    input  logic                m_ready,
    output nvqp_pkg::result_t   m_res
);

    nvqp_pkg::result_t cur_reg;
    nvqp_pkg::result_t nxt_reg;
    logic [1:0]        cnt_reg, cnt_next;
    logic              fire;

    assign m_valid = (cnt_reg != 2'd0);
    assign m_res   = cur_reg;
    assign fire    = m_valid && m_ready;

    // New pair may enter once the current contents leave this cycle
    assign load_ok = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);

    always_comb begin
        cnt_next = cnt_reg - {1'b0, fire};
        if (load) begin
            cnt_next = pair.n;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= pair.r0;
            nxt_reg <= pair.r1;
        end else if (fire) begin
            cur_reg <= nxt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result count out of range");

    a_pair_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && pair.n == 2'd2) |=> (cnt_reg == 2'd2 && !cur_reg.last && nxt_reg.last))
        else $error("result pair not held as loaded");

endmodule

/* tb/nvme_io_queue_pair_host_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// nvme_io_queue_pair_host_tb: self-checking bench for the I/O queue pair host
// Drives commands and completion entries on the input stream, predicts the
// submission entries, doorbell writes and status reports in a local model of
// the ring pointers, phase and command id, and checks every result transfer
// in order. Covers register extremes, ring wrap and back-pressure.
// ============================================================================
module nvme_io_queue_pair_host_tb;

    localparam logic FUNC_COMPLETE = 1'b1;

    // Doorbell slots of queue 1: SQ tail at 2 * qid, CQ head at 2 * qid + 1
    localparam int unsigned SQ_BELL_INDEX = 2;
    localparam int unsigned CQ_BELL_INDEX = 3;

    // Longest legal quiet stretch is the deliberate sink hold
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RANDOM_ROUNDS    = 4;
    localparam int ROUND_ITEMS      = 125;

    // Result payload as it sits in m_tdata (first struct member = top bits)
    typedef struct packed {
        logic [nvqp_pkg::ERR_W-1:0]  error_code;
        logic [nvqp_pkg::PTR_W-1:0]  bell_value;
        logic [nvqp_pkg::BELL_W-1:0] bell_offset;
        logic [15:0]                 count_out;
        logic [63:0]                 lba_out;
        logic [63:0]                 prp_addr;
        logic [31:0]                 ns_out;
        logic [nvqp_pkg::ID_W-1:0]   cmd_id;
        logic [7:0]                  opcode;
        logic [nvqp_pkg::PTR_W-1:0]  slot;
    } m_payload_t;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [nvqp_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [nvqp_pkg::CFG_DATA_W-1:0]   cfg_wdata;
    logic                              s_tvalid;
    logic                              s_tready;
    // low to high: is_write, start_block, block_count, data_addr, cqe_id,
    //   cqe_status, 7 zero pad bits
    logic [nvqp_pkg::S_TDATA_W-1:0]    s_tdata;
    // func
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    // low to high: slot, opcode, cmd_id, ns_out, prp_addr, lba_out, count_out,
    //   bell_offset, bell_value, error_code
    logic [nvqp_pkg::M_TDATA_W-1:0]    m_tdata;
    // kind
    logic [1:0]                        m_tuser;
    logic                              m_tlast;

    nvme_io_queue_pair_host dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Local model of the host queue pair: registers and ring state
    // ------------------------------------------------------------------
    logic [nvqp_pkg::DEPTH_W-1:0] ring_depth;
    logic [3:0]                   stride_log;
    logic [31:0]                  ns_id;
    logic [nvqp_pkg::PTR_W-1:0]   sq_tail;
    logic [nvqp_pkg::PTR_W-1:0]   cq_head;
    logic                         cq_phase;
    logic [nvqp_pkg::ID_W-1:0]    next_cmd_id;
    logic [nvqp_pkg::ID_W-1:0]    pending_id;
    logic                         pending_valid;

    nvqp_pkg::result_t due_results[$];     // results predicted but not yet seen

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    bit  src_idle       = 1'b1;  // sender inserts random gaps
    bit  sink_idle      = 1'b1;  // receiver inserts random stalls
    int  hold_request   = 0;     // one-shot long stall for the receiver

    // Pointer advance; depth is clamped to [2, DEPTH_CAP], and a pointer left
    // beyond a lowered depth falls back to slot 0
    function automatic logic [nvqp_pkg::PTR_W-1:0] ring_next(
        input logic [nvqp_pkg::PTR_W-1:0] p
    );
        int lim;
        int n;
        lim = ring_depth;
        if (lim > nvqp_pkg::DEPTH_CAP) lim = nvqp_pkg::DEPTH_CAP;
        if (lim < 2) lim = 2;
        n = p + 1;
        return (n >= lim) ? '0 : n[nvqp_pkg::PTR_W-1:0];
    endfunction

    function automatic logic [nvqp_pkg::BELL_W-1:0] doorbell_addr(
        input int unsigned idx
    );
        int unsigned off;
        off = idx * (32'd4 << stride_log);
        return nvqp_pkg::BELL_BASE + off[nvqp_pkg::BELL_W-1:0];
    endfunction

    // Advance the model by one accepted item and queue the results it causes
    task automatic step_queue_pair(input nvqp_pkg::in_item_t it);
        nvqp_pkg::result_t           r;
        logic [nvqp_pkg::ID_W-1:0]   id;
        logic [nvqp_pkg::ERR_W-1:0]  code;
        if (it.func == nvqp_pkg::FUNC_SUBMIT) begin
            id          = next_cmd_id;
            next_cmd_id = next_cmd_id + 1'b1;     // wraps 0xFFFF -> 0
            r           = '0;
            r.kind      = nvqp_pkg::KIND_SQE;
            r.slot      = sq_tail;
            r.opcode    = it.is_write ? nvqp_pkg::OP_WRITE : nvqp_pkg::OP_READ;
            r.cmd_id    = id;
            r.ns_out    = ns_id;
            r.prp_addr  = it.data_addr;
            r.lba_out   = it.start_block;
            r.count_out = it.block_count;
            due_results.push_back(r);
            sq_tail       = ring_next(sq_tail);
            pending_id    = id;                    // newest command wins
            pending_valid = 1'b1;
            r             = '0;
            r.kind        = nvqp_pkg::KIND_BELL;
            r.bell_offset = doorbell_addr(SQ_BELL_INDEX);
            r.bell_value  = sq_tail;
            r.last        = 1'b1;
            due_results.push_back(r);
        end else begin
            code = it.cqe_status[15:1];
            // nothing outstanding, stale phase or foreign id: dropped silently
            if (pending_valid && it.cqe_status[0] == cq_phase
                && it.cqe_id == pending_id) begin
                pending_valid = 1'b0;
                if (code != '0) begin
                    r            = '0;
                    r.kind       = nvqp_pkg::KIND_FAIL;
                    r.cmd_id     = it.cqe_id;
                    r.error_code = code;
                    r.last       = 1'b1;
                    due_results.push_back(r);
                end else begin
                    cq_head = ring_next(cq_head);
                    if (cq_head == '0) cq_phase = ~cq_phase;
                    r             = '0;
                    r.kind        = nvqp_pkg::KIND_BELL;
                    r.bell_offset = doorbell_addr(CQ_BELL_INDEX);
                    r.bell_value  = cq_head;
                    due_results.push_back(r);
                    r        = '0;
                    r.kind   = nvqp_pkg::KIND_OK;
                    r.cmd_id = it.cqe_id;
                    r.last   = 1'b1;
                    due_results.push_back(r);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Unused fields carry random bits too; the block must ignore them
    function automatic nvqp_pkg::in_item_t random_fields();
        nvqp_pkg::in_item_t it;
        it.func        = 1'($urandom_range(0, 1));
        it.is_write    = 1'($urandom_range(0, 1));
        it.start_block = rand64();
        it.block_count = 16'($urandom);
        it.data_addr   = rand64();
        it.cqe_id      = 16'($urandom);
        it.cqe_status  = 16'($urandom);
        return it;
    endfunction

    function automatic nvqp_pkg::in_item_t submit_item(input logic wr,
                                                       input logic [63:0] lba,
                                                       input logic [15:0] cnt,
                                                       input logic [63:0] addr);
        nvqp_pkg::in_item_t it;
        it             = random_fields();
        it.func        = nvqp_pkg::FUNC_SUBMIT;
        it.is_write    = wr;
        it.start_block = lba;
        it.block_count = cnt;
        it.data_addr   = addr;
        return it;
    endfunction

    function automatic nvqp_pkg::in_item_t any_submit();
        return submit_item(1'($urandom_range(0, 1)), rand64(), 16'($urandom), rand64());
    endfunction

    function automatic nvqp_pkg::in_item_t completion_item(
        input logic [nvqp_pkg::ID_W-1:0] id,
        input logic [15:0]               status
    );
        nvqp_pkg::in_item_t it;
        it            = random_fields();
        it.func       = FUNC_COMPLETE;
        it.cqe_id     = id;
        it.cqe_status = status;
        return it;
    endfunction

    // Good completion for whatever the model has outstanding
    function automatic nvqp_pkg::in_item_t good_completion();
        return completion_item(pending_id, {15'd0, cq_phase});
    endfunction

    // Mostly well-formed traffic: submits and matching completions, with a
    // share of stale-phase, wrong-id and fully random completion entries
    function automatic nvqp_pkg::in_item_t pick_item();
        nvqp_pkg::in_item_t          it;
        int                          roll;
        logic [nvqp_pkg::ERR_W-1:0]  code;
        roll = $urandom_range(0, 99);
        code = ($urandom_range(0, 99) < 65) ? '0
                                             : nvqp_pkg::ERR_W'($urandom_range(1, 32767));
        if (roll < 45)
            it = any_submit();
        else if (roll < 82 && pending_valid)
            it = completion_item(pending_id, {code, cq_phase});
        else if (roll < 88)
            it = completion_item(pending_id, {code, ~cq_phase});
        else if (roll < 94)
            it = completion_item(pending_id ^ 16'($urandom_range(1, 65535)), {code, cq_phase});
        else
            it = completion_item(16'($urandom), 16'($urandom));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Shared driver tasks (called at a rising edge, return at one)
    // ------------------------------------------------------------------
    task automatic send_item(input nvqp_pkg::in_item_t it);
        int gap;
        gap = src_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {7'd0, it.cqe_status, it.cqe_id, it.data_addr, it.block_count,
                     it.start_block, it.is_write};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        step_queue_pair(it);
    endtask

    // Stop offering, wait out every predicted result, then let any ignored
    // completion still in the pipe settle before config may change
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [nvqp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            nvqp_pkg::REG_QUEUE_DEPTH:  ring_depth = value[nvqp_pkg::DEPTH_W-1:0];
            nvqp_pkg::REG_STRIDE_LOG:   stride_log = value[3:0];
            nvqp_pkg::REG_NAMESPACE_ID: ns_id      = value;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [31:0] depth, input logic [31:0] stride,
                                  input logic [31:0] ns);
        write_reg(nvqp_pkg::REG_QUEUE_DEPTH, depth);
        write_reg(nvqp_pkg::REG_STRIDE_LOG, stride);
        write_reg(nvqp_pkg::REG_NAMESPACE_ID, ns);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Opcodes, field extremes, good/failed status and every ignored case
    task automatic test_basic_commands();
        logic [nvqp_pkg::ID_W-1:0] older;
        send_item(submit_item(1'b0, '0, '0, '0));             // read, all zeros
        send_item(good_completion());
        send_item(completion_item(16'hFFFF, 16'hFFFF));       // nothing outstanding
        send_item(submit_item(1'b1, '1, '1, '1));             // write, all ones
        send_item(completion_item(pending_id, {15'd0, ~cq_phase}));        // stale phase
        send_item(completion_item(pending_id ^ 16'h8001, {15'd0, cq_phase})); // wrong id
        send_item(completion_item(pending_id, {15'h7FFF, cq_phase}));      // top status code
        send_item(any_submit());
        send_item(completion_item(pending_id, {15'h0001, cq_phase}));      // lowest code
        // a second submit replaces the outstanding command
        send_item(any_submit());
        older = pending_id;
        send_item(any_submit());
        send_item(completion_item(older, {15'd0, cq_phase}));
        send_item(good_completion());
        send_item(good_completion());                         // already retired
    endtask

    // Register extremes; two command/completion pairs per setting so that
    // a clamped depth of 2 wraps the head and flips the phase
    task automatic test_register_settings();
        for (int k = 0; k < 4; k++) begin
            wait_drained();
            case (k)
                0: write_all_regs(32'd0, 32'd15, 32'h0000_0000);
                1: write_all_regs(32'd1, 32'd0, 32'hFFFF_FFFF);
                2: write_all_regs(32'd63, 32'd7, $urandom);
                default: write_all_regs(32'd33, 32'd3, 32'd1);
            endcase
            repeat (2) begin
                send_item(any_submit());
                send_item(good_completion());
            end
        end
    endtask

    // Walk tail and head past slot 5, then shrink the ring under them
    task automatic test_pointer_beyond_depth();
        wait_drained();
        write_reg(nvqp_pkg::REG_QUEUE_DEPTH, 32'd32);
        while (sq_tail < 6 || cq_head < 6) begin
            send_item(any_submit());
            send_item(good_completion());
        end
        wait_drained();
        write_reg(nvqp_pkg::REG_QUEUE_DEPTH, 32'd2);
        send_item(any_submit());
        send_item(good_completion());
    endtask

    // Long receiver hold while the sender keeps pushing, then a full pause
    task automatic test_backpressure();
        wait_drained();
        src_idle     = 1'b0;
        hold_request = SINK_HOLD_CYCLES;
        repeat (24) send_item(any_submit());
        wait_drained();
        src_idle = 1'b1;
        send_item(good_completion());
        send_item(any_submit());
        send_item(good_completion());
    endtask

    task automatic test_random_traffic();
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            wait_drained();
            case (round)
                0: write_all_regs(32'd0, 32'd15, 32'hFFFF_FFFF);
                1: write_all_regs(32'd63, 32'd0, $urandom);
                2: write_all_regs({16'($urandom_range(0, 65535)), 10'd0,
                                   6'($urandom_range(0, 63))},
                                  $urandom_range(0, 15), $urandom);
                default: write_all_regs(32'd3, $urandom_range(0, 15), 32'd0);
            endcase
            for (int i = 0; i < ROUND_ITEMS; i++) begin
                // alternate stretches with and without idling on each side
                if (i % 25 == 0) begin
                    src_idle  = ($urandom_range(0, 3) != 0);
                    sink_idle = ($urandom_range(0, 3) != 0);
                end
                send_item(pick_item());
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result receiver: per-result stall draw, plus one-shot long hold
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request > 0) begin
                gap          = hold_request;
                hold_request = 0;
            end else begin
                gap = sink_idle ? $urandom_range(0, 16) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: in-order compare against the model
    // ------------------------------------------------------------------
    function automatic void show_result(input string tag, input nvqp_pkg::result_t r);
        $display("  %s kind=%0d slot=%0d op=%h id=%h ns=%h count=%h last=%b",
                 tag, r.kind, r.slot, r.opcode, r.cmd_id, r.ns_out, r.count_out, r.last);
        $display("  %s prp=%h lba=%h bell=%h/%0d err=%h",
                 tag, r.prp_addr, r.lba_out, r.bell_offset, r.bell_value, r.error_code);
    endfunction

    always @(posedge aclk) begin : check_results
        m_payload_t         pl;
        nvqp_pkg::result_t  got;
        nvqp_pkg::result_t  want;
        logic [11:0]        bad;
        if (aresetn && m_tvalid && m_tready) begin
            pl              = m_tdata;
            got.kind        = nvqp_pkg::kind_t'(m_tuser);
            got.slot        = pl.slot;
            got.opcode      = pl.opcode;
            got.cmd_id      = pl.cmd_id;
            got.ns_out      = pl.ns_out;
            got.prp_addr    = pl.prp_addr;
            got.lba_out     = pl.lba_out;
            got.count_out   = pl.count_out;
            got.bell_offset = pl.bell_offset;
            got.bell_value  = pl.bell_value;
            got.error_code  = pl.error_code;
            got.last        = m_tlast;
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("[%0t] result transfer with nothing expected", $time);
                    show_result("actual  ", got);
                end
            end else begin
                want = due_results.pop_front();
                // flags, kind first down to last
                bad = {got.kind !== want.kind, got.slot !== want.slot,
                       got.opcode !== want.opcode, got.cmd_id !== want.cmd_id,
                       got.ns_out !== want.ns_out, got.prp_addr !== want.prp_addr,
                       got.lba_out !== want.lba_out, got.count_out !== want.count_out,
                       got.bell_offset !== want.bell_offset,
                       got.bell_value !== want.bell_value,
                       got.error_code !== want.error_code, got.last !== want.last};
                if (bad != '0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("[%0t] result mismatch, field flags %b", $time, bad);
                        show_result("expected", want);
                        show_result("actual  ", got);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no transfer on either side ends the run
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("nvme_io_queue_pair_host test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= nvqp_pkg::REG_QUEUE_DEPTH;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= nvqp_pkg::FUNC_SUBMIT;

        // model state after reset
        ring_depth    = nvqp_pkg::QUEUE_DEPTH_RST;
        stride_log    = nvqp_pkg::STRIDE_LOG_RST;
        ns_id         = nvqp_pkg::NAMESPACE_RST;
        sq_tail       = '0;
        cq_head       = '0;
        cq_phase      = 1'b1;
        next_cmd_id   = 16'd1;
        pending_id    = '0;
        pending_valid = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_commands();
        test_register_settings();
        test_pointer_beyond_depth();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        if (mismatch_count == 0) begin
            $display("nvme_io_queue_pair_host test passed");
        end else begin
            $display("nvme_io_queue_pair_host test failed");
        end
        $finish;
    end

endmodule
